// ===== rtl/core/ubxr_pkg.sv =====
// ----------------------------------------------------------------------------
// ubxr_pkg
// shared types and constants of the ubx frame receiver
// ----------------------------------------------------------------------------
package ubxr_pkg;

    localparam int STORE_BYTES_DEF = 64;

    localparam logic [7:0] SYNC_CHAR1 = 8'hB5;
    localparam logic [7:0] SYNC_CHAR2 = 8'h62;

    // frame overhead taken off STORE_BYTES; the payload store holds only the payload
    localparam int FRAME_OVERHEAD = 6;
    localparam int CHECK_BYTES    = 2;

    localparam int CNT_W = 17;

    localparam logic [1:0] ST_GOOD   = 2'd0;
    localparam logic [1:0] ST_CKSUM  = 2'd1;
    localparam logic [1:0] ST_LONG   = 2'd2;

    localparam int JQ_DEPTH = 2;
    localparam int JQ_AW    = $clog2(JQ_DEPTH);
    localparam int JQ_CW    = $clog2(JQ_DEPTH + 1);

    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);
    localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

    typedef enum logic [1:0] {
        FR_HUNT,
        FR_HEADER,
        FR_BODY,
        FR_SKIP
    } front_state_t;

    typedef enum logic {
        BK_IDLE,
        BK_BURST
    } back_state_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        burst;
        logic [7:0]  msg_class;
        logic [7:0]  msg_id;
        logic [15:0] len;
        logic [7:0]  drop;
    } job_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  msg_class;
        logic [7:0]  msg_id;
        logic [15:0] payload_length;
        logic [7:0]  payload_byte;
        logic        byte_valid;
        logic        last;
        logic [7:0]  drop_count;
    } item_t;

endpackage

// ===== rtl/core/ubx_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// ubx_frame_receiver
// ubx frame parser with 8-bit fletcher check, payload bytes out one per result
//
//   channel   handshake        fields
//   -------   --------------   ---------------------------------------------
//   bytes in  push / full      rx_byte
//   results   pop / empty      status, msg_class, msg_id, payload_length,
//                              payload_byte, byte_valid, last, drop_count
//
// one received byte is taken per cycle while parsing and full is low; the parser
// classifies each frame and queues a job for the emitter.
// after a good frame with a non-empty payload, input is held off until the
// payload store has been read out, one byte per cycle while the result queue
// has room, over its single read port.
// reset is asynchronous; the payload store has no clearing pass.
// ----------------------------------------------------------------------------
module ubx_frame_receiver #(
    parameter  int STORE_BYTES = ubxr_pkg::STORE_BYTES_DEF,
    localparam int PAY_DEPTH   = STORE_BYTES - ubxr_pkg::FRAME_OVERHEAD,
    localparam int AW          = $clog2(PAY_DEPTH)
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  rx_byte,
    input  logic        push,
    output logic        full,
    output logic [1:0]  status,
    output logic [7:0]  msg_class,
    output logic [7:0]  msg_id,
    output logic [15:0] payload_length,
    output logic [7:0]  payload_byte,
    output logic        byte_valid,
    output logic        last,
    output logic [7:0]  drop_count,
    output logic        empty,
    input  logic        pop
);
    import ubxr_pkg::*;

    logic           mem_we;
    logic [AW-1:0]  mem_addr;
    logic [7:0]     mem_data;
    logic           jq_push;
    job_t           jq_wr_job;
    logic           jq_full;
    logic           jq_pop;
    job_t           jq_rd_job;
    logic           jq_empty;
    logic           burst_done;
    logic           front_busy;
    item_t          out_item;

    ubxr_front #(
        .STORE_BYTES (STORE_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx_byte    (rx_byte),
        .push       (push),
        .full       (full),
        .mem_we     (mem_we),
        .mem_addr   (mem_addr),
        .mem_data   (mem_data),
        .jq_push    (jq_push),
        .jq_job     (jq_wr_job),
        .jq_full    (jq_full),
        .burst_done (burst_done),
        .busy       (front_busy)
    );

    ubxr_job_fifo u_job_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (jq_push),
        .wr_job   (jq_wr_job),
        .jq_full  (jq_full),
        .rd_en    (jq_pop),
        .rd_job   (jq_rd_job),
        .jq_empty (jq_empty)
    );

    ubxr_back #(
        .STORE_BYTES (STORE_BYTES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .mem_we     (mem_we),
        .mem_addr   (mem_addr),
        .mem_data   (mem_data),
        .jq_empty   (jq_empty),
        .jq_job     (jq_rd_job),
        .jq_pop     (jq_pop),
        .burst_done (burst_done),
        .out_empty  (empty),
        .out_pop    (pop),
        .out_item   (out_item)
    );

    assign status         = out_item.status;
    assign msg_class      = out_item.msg_class;
    assign msg_id         = out_item.msg_id;
    assign payload_length = out_item.payload_length;
    assign payload_byte   = out_item.payload_byte;
    assign byte_valid     = out_item.byte_valid;
    assign last           = out_item.last;
    assign drop_count     = out_item.drop_count;

    a_job_queue_room: assert property (
        @(posedge clk) disable iff (!rst_n) jq_push |-> !jq_full
    ) else $error("job pushed into a full queue");

    a_store_quiet_in_burst: assert property (
        @(posedge clk) disable iff (!rst_n) mem_we |-> !front_busy
    ) else $error("payload store written during readout");

    a_done_while_busy: assert property (
        @(posedge clk) disable iff (!rst_n) burst_done |-> front_busy
    ) else $error("burst done without a pending burst");

    a_busy_holds_input: assert property (
        @(posedge clk) disable iff (!rst_n) $rose(front_busy) |-> full && $past(jq_push)
    ) else $error("busy rose without a queued burst");

endmodule

// ===== rtl/core/ubxr_job_fifo.sv =====
// ----------------------------------------------------------------------------
// ubxr_job_fifo
// short queue of frame jobs between parser and result emitter
// ----------------------------------------------------------------------------
module ubxr_job_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  ubxr_pkg::job_t  wr_job,
    output logic            jq_full,
    input  logic            rd_en,
    output ubxr_pkg::job_t  rd_job,
    output logic            jq_empty
);
    import ubxr_pkg::*;

    job_t               slot_mem [JQ_DEPTH];
    logic [JQ_AW-1:0]   wr_ptr_reg;
    logic [JQ_AW-1:0]   wr_ptr_next;
    logic [JQ_AW-1:0]   rd_ptr_reg;
    logic [JQ_AW-1:0]   rd_ptr_next;
    logic [JQ_CW-1:0]   count_reg;
    logic [JQ_CW-1:0]   count_next;
    logic               do_wr;
    logic               do_rd;

    assign jq_full  = (count_reg == JQ_CW'(JQ_DEPTH));
    assign jq_empty = (count_reg == '0);
    assign do_wr    = wr_en && !jq_full;
    assign do_rd    = rd_en && !jq_empty;
    assign rd_job   = slot_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == JQ_AW'(JQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == JQ_AW'(JQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_mem[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

// ===== rtl/core/ubxr_front.sv =====
// ----------------------------------------------------------------------------
// ubxr_front
// sync hunt, header capture, fletcher check and frame classification
// ----------------------------------------------------------------------------
module ubxr_front #(
    parameter  int STORE_BYTES = ubxr_pkg::STORE_BYTES_DEF,
    localparam int PAY_DEPTH   = STORE_BYTES - ubxr_pkg::FRAME_OVERHEAD,
    localparam int AW          = $clog2(PAY_DEPTH)
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [7:0]      rx_byte,
    input  logic            push,
    output logic            full,
    output logic            mem_we,
    output logic [AW-1:0]   mem_addr,
    output logic [7:0]      mem_data,
    output logic            jq_push,
    output ubxr_pkg::job_t  jq_job,
    input  logic            jq_full,
    input  logic            burst_done,
    output logic            busy
);
    import ubxr_pkg::*;

    front_state_t       state_reg;
    front_state_t       state_next;
    logic               sync_reg;
    logic               sync_next;
    logic [7:0]         class_reg;
    logic [7:0]         class_next;
    logic [7:0]         id_reg;
    logic [7:0]         id_next;
    logic [15:0]        len_reg;
    logic [15:0]        len_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic [7:0]         sum_a_reg;
    logic [7:0]         sum_a_next;
    logic [7:0]         sum_b_reg;
    logic [7:0]         sum_b_next;
    logic [7:0]         ck_a_reg;
    logic [7:0]         ck_a_next;
    logic [7:0]         drop_reg;
    logic [7:0]         drop_next;
    logic               busy_reg;
    logic               busy_next;

    logic               accept;
    logic [7:0]         sum_a_upd;
    logic [7:0]         sum_b_upd;
    logic [1:0]         hdr_idx;
    logic [15:0]        len_full;
    logic               too_long;
    logic [CNT_W-1:0]   len_ext;
    logic               in_payload;
    logic               at_check_a;
    logic               body_end;
    logic               check_ok;
    logic               sync_start;

    assign full       = busy_reg || jq_full;
    assign busy       = busy_reg;
    assign accept     = push && !full;
    assign sum_a_upd  = sum_a_reg + rx_byte;
    assign sum_b_upd  = sum_b_reg + sum_a_upd;
    assign hdr_idx    = cnt_reg[1:0];
    assign len_full   = {rx_byte, len_reg[7:0]};
    assign too_long   = (len_full > 16'(PAY_DEPTH));
    assign len_ext    = CNT_W'(len_reg);
    assign in_payload = (cnt_reg < len_ext);
    assign at_check_a = (cnt_reg == len_ext);
    assign body_end   = (cnt_reg == len_ext + CNT_W'(CHECK_BYTES - 1));
    assign check_ok   = (ck_a_reg == sum_a_reg) && (rx_byte == sum_b_reg);
    assign sync_start = sync_reg && (rx_byte == SYNC_CHAR2);

    // next state
    always_comb
    begin
        state_next = state_reg;
        if (accept)
        begin
            unique case (state_reg)
                FR_HUNT:
                begin
                    if (sync_start)
                    begin
                        state_next = FR_HEADER;
                    end
                end
                FR_HEADER:
                begin
                    if (hdr_idx == 2'd3)
                    begin
                        state_next = too_long ? FR_SKIP : FR_BODY;
                    end
                end
                FR_BODY:
                begin
                    if (body_end)
                    begin
                        state_next = FR_HUNT;
                    end
                end
                FR_SKIP:
                begin
                    if (cnt_reg <= CNT_W'(1))
                    begin
                        state_next = FR_HUNT;
                    end
                end
                default:
                begin
                    state_next = FR_HUNT;
                end
            endcase
        end
    end

    // datapath and outputs
    always_comb
    begin
        sync_next  = sync_reg;
        class_next = class_reg;
        id_next    = id_reg;
        len_next   = len_reg;
        cnt_next   = cnt_reg;
        sum_a_next = sum_a_reg;
        sum_b_next = sum_b_reg;
        ck_a_next  = ck_a_reg;
        drop_next  = drop_reg;
        busy_next  = busy_reg;
        mem_we     = 1'b0;
        mem_addr   = cnt_reg[AW-1:0];
        mem_data   = rx_byte;
        jq_push    = 1'b0;
        jq_job     = '0;
        jq_job.msg_class = class_reg;
        jq_job.msg_id    = id_reg;
        jq_job.len       = len_reg;
        jq_job.drop      = drop_reg;

        if (burst_done)
        begin
            busy_next = 1'b0;
        end

        if (accept)
        begin
            unique case (state_reg)
                FR_HUNT:
                begin
                    sync_next = (rx_byte == SYNC_CHAR1);
                    if (sync_start)
                    begin
                        cnt_next   = '0;
                        sum_a_next = '0;
                        sum_b_next = '0;
                    end
                end
                FR_HEADER:
                begin
                    sum_a_next = sum_a_upd;
                    sum_b_next = sum_b_upd;
                    cnt_next   = cnt_reg + 1'b1;
                    unique case (hdr_idx)
                        2'd0: class_next = rx_byte;
                        2'd1: id_next = rx_byte;
                        2'd2: len_next = {len_reg[15:8], rx_byte};
                        default:
                        begin
                            len_next = len_full;
                            if (too_long)
                            begin
                                drop_next     = drop_reg + 1'b1;
                                cnt_next      = CNT_W'(len_full) + CNT_W'(CHECK_BYTES);
                                jq_push       = 1'b1;
                                jq_job.status = ST_LONG;
                                jq_job.len    = len_full;
                                jq_job.drop   = drop_reg + 1'b1;
                            end
                            else
                            begin
                                cnt_next = '0;
                            end
                        end
                    endcase
                end
                FR_BODY:
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if (in_payload)
                    begin
                        sum_a_next = sum_a_upd;
                        sum_b_next = sum_b_upd;
                        mem_we     = 1'b1;
                    end
                    if (at_check_a)
                    begin
                        ck_a_next = rx_byte;
                    end
                    if (body_end)
                    begin
                        cnt_next = '0;
                        jq_push  = 1'b1;
                        if (check_ok)
                        begin
                            jq_job.status = ST_GOOD;
                            jq_job.burst  = (len_reg != '0);
                            busy_next     = (len_reg != '0);
                        end
                        else
                        begin
                            drop_next     = drop_reg + 1'b1;
                            jq_job.status = ST_CKSUM;
                            jq_job.drop   = drop_reg + 1'b1;
                        end
                    end
                end
                FR_SKIP:
                begin
                    if (cnt_reg != '0)
                    begin
                        cnt_next = cnt_reg - 1'b1;
                    end
                end
                default:
                begin
                    sync_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FR_HUNT;
            sync_reg  <= 1'b0;
            class_reg <= '0;
            id_reg    <= '0;
            len_reg   <= '0;
            cnt_reg   <= '0;
            sum_a_reg <= '0;
            sum_b_reg <= '0;
            drop_reg  <= '0;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sync_reg  <= sync_next;
            class_reg <= class_next;
            id_reg    <= id_next;
            len_reg   <= len_next;
            cnt_reg   <= cnt_next;
            sum_a_reg <= sum_a_next;
            sum_b_reg <= sum_b_next;
            drop_reg  <= drop_next;
            busy_reg  <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ck_a_reg <= ck_a_next;
    end

endmodule

// ===== rtl/core/ubxr_back.sv =====
// ----------------------------------------------------------------------------
// ubxr_back
// payload store, result emitter and result queue
// ----------------------------------------------------------------------------
module ubxr_back #(
    parameter  int STORE_BYTES = ubxr_pkg::STORE_BYTES_DEF,
    localparam int PAY_DEPTH   = STORE_BYTES - ubxr_pkg::FRAME_OVERHEAD,
    localparam int AW          = $clog2(PAY_DEPTH)
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            mem_we,
    input  logic [AW-1:0]   mem_addr,
    input  logic [7:0]      mem_data,
    input  logic            jq_empty,
    input  ubxr_pkg::job_t  jq_job,
    output logic            jq_pop,
    output logic            burst_done,
    output logic            out_empty,
    input  logic            out_pop,
    output ubxr_pkg::item_t out_item
);
    import ubxr_pkg::*;

    logic [7:0]         pay_mem [PAY_DEPTH];
    logic [7:0]         rd_data_reg;

    back_state_t        state_reg;
    back_state_t        state_next;
    job_t               job_reg;
    logic [AW-1:0]      idx_reg;
    logic               pend_reg;
    item_t              pitem_reg;

    item_t              oq_mem [OQ_DEPTH];
    logic [OQ_AW-1:0]   oq_wr_ptr_reg;
    logic [OQ_AW-1:0]   oq_rd_ptr_reg;
    logic [OQ_CW-1:0]   oq_cnt_reg;
    logic [OQ_CW-1:0]   oq_cnt_next;

    logic               issue_ok;
    logic               last_idx;
    logic               issue;
    logic               rd_en;
    item_t              issue_item;
    item_t              oq_wr_item;
    logic               oq_pop;

    // room for the queued items plus the one in the read stage
    assign issue_ok = (oq_cnt_reg + OQ_CW'(pend_reg)) <= OQ_CW'(OQ_DEPTH - 2);
    assign last_idx = (16'(idx_reg) == job_reg.len - 16'd1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!jq_empty && issue_ok && jq_job.burst)
                begin
                    state_next = BK_BURST;
                end
            end
            BK_BURST:
            begin
                if (issue_ok && last_idx)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        jq_pop     = 1'b0;
        issue      = 1'b0;
        rd_en      = 1'b0;
        burst_done = 1'b0;
        issue_item = '0;
        unique case (state_reg)
            BK_IDLE:
            begin
                jq_pop                    = !jq_empty && issue_ok;
                issue                     = jq_pop && !jq_job.burst;
                issue_item.status         = jq_job.status;
                issue_item.msg_class      = jq_job.msg_class;
                issue_item.msg_id         = jq_job.msg_id;
                issue_item.payload_length = jq_job.len;
                issue_item.last           = 1'b1;
                issue_item.drop_count     = jq_job.drop;
            end
            BK_BURST:
            begin
                issue                     = issue_ok;
                rd_en                     = issue_ok;
                burst_done                = issue_ok && last_idx;
                issue_item.status         = ST_GOOD;
                issue_item.msg_class      = job_reg.msg_class;
                issue_item.msg_id         = job_reg.msg_id;
                issue_item.payload_length = job_reg.len;
                issue_item.byte_valid     = 1'b1;
                issue_item.last           = last_idx;
                issue_item.drop_count     = job_reg.drop;
            end
            default:
            begin
                issue = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            pay_mem[mem_addr] <= mem_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= pay_mem[idx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            idx_reg   <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= issue;
            if (jq_pop)
            begin
                idx_reg <= '0;
            end
            else if (rd_en)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (jq_pop)
        begin
            job_reg <= jq_job;
        end
        if (issue)
        begin
            pitem_reg <= issue_item;
        end
    end

    // result queue
    always_comb
    begin
        oq_wr_item              = pitem_reg;
        oq_wr_item.payload_byte = pitem_reg.byte_valid ? rd_data_reg : 8'd0;
    end

    assign out_empty = (oq_cnt_reg == '0);
    assign oq_pop    = out_pop && !out_empty;
    assign out_item  = oq_mem[oq_rd_ptr_reg];

    always_comb
    begin
        oq_cnt_next = oq_cnt_reg;
        if (pend_reg && !oq_pop)
        begin
            oq_cnt_next = oq_cnt_reg + 1'b1;
        end
        else if (oq_pop && !pend_reg)
        begin
            oq_cnt_next = oq_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_ptr_reg <= '0;
            oq_rd_ptr_reg <= '0;
            oq_cnt_reg    <= '0;
        end
        else
        begin
            oq_cnt_reg <= oq_cnt_next;
            if (pend_reg)
            begin
                oq_wr_ptr_reg <= oq_wr_ptr_reg + 1'b1;
            end
            if (oq_pop)
            begin
                oq_rd_ptr_reg <= oq_rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_reg)
        begin
            oq_mem[oq_wr_ptr_reg] <= oq_wr_item;
        end
    end

endmodule
